// File: hdl/dlpe_pkg.sv
package dlpe_pkg;

  // item kinds
  localparam logic [1:0] KIND_ROW   = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_LDELTA  = 2'd0;
  localparam logic [1:0] CFG_LDELTA_SPAN = 2'd1;
  localparam logic [1:0] CFG_CODE_START  = 2'd2;

  // configuration reset values
  localparam logic [7:0]  RST_MIN_LDELTA  = 8'd1;
  localparam logic [7:0]  RST_LDELTA_SPAN = 8'd7;
  localparam logic [63:0] RST_CODE_START  = 64'h0000_0000_0040_1000;

  // standard and extended opcodes
  localparam logic [7:0] OP_EXTENDED      = 8'h00;
  localparam logic [7:0] OP_COPY          = 8'h01;
  localparam logic [7:0] OP_ADVANCE_PC    = 8'h02;
  localparam logic [7:0] OP_ADVANCE_LINE  = 8'h03;
  localparam logic [7:0] EXT_END_SEQUENCE = 8'h01;
  localparam logic [7:0] EXT_SET_ADDRESS  = 8'h02;
  localparam logic [7:0] END_SEQ_LEN      = 8'h01;
  localparam logic [7:0] SPECIAL_MIN      = 8'd7;
  localparam logic [7:0] SPECIAL_MAX      = 8'd255;

  // signed deltas of two 32-bit values need 33 bits
  localparam int DIFF_W = 33;

  // classified-item queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [1:0]               kind;
    logic                     special;
    logic [7:0]               op;
    logic signed [DIFF_W-1:0] pd;
    logic signed [DIFF_W-1:0] ld;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qlink_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_SLEB_PD,
    PH_ADV_LINE,
    PH_SLEB_LD,
    PH_COPY,
    PH_BEG_LEN,
    PH_BEG_OP,
    PH_BEG_ADDR,
    PH_END_EXT,
    PH_END_LEN,
    PH_END_OP
  } phase_t;

endpackage

// File: hdl/dlpe_ifs.sv
// input channel: one row, begin or end item
interface dlpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] pc_offset;
  logic [31:0] line_number;

  modport source (output valid, output kind, output pc_offset, output line_number,
                  input ready);
  modport sink   (input valid, input kind, input pc_offset, input line_number,
                  output ready);
endinterface

// result channel: one program byte
interface dlpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// File: hdl/dlpe_front.sv
module dlpe_front
  import dlpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dlpe_in_if.sink     in_ch,
  input  logic [7:0]  min_ldelta,
  input  logic [7:0]  ldelta_span,
  output qlink_t      push,
  input  logic        push_ready
);

  logic [31:0]              cur_off_r, cur_off_nxt;
  logic [31:0]              cur_line_r, cur_line_nxt;
  logic                     s1_v_r, s1_v_nxt;
  logic [1:0]               s1_kind_r;
  logic signed [DIFF_W-1:0] s1_pd_r, s1_ld_r;
  logic                     accept;

  logic [DIFF_W:0]  lb_ext;
  logic [DIFF_W:0]  dl;
  logic             in_rng;
  logic             pd_small;
  logic [15:0]      prod;
  logic [16:0]      op_sum;

  assign in_ch.ready = !s1_v_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // state tracking and delta stage
  always_comb begin
    cur_off_nxt  = cur_off_r;
    cur_line_nxt = cur_line_r;
    s1_v_nxt     = s1_v_r && !push_ready;
    if (accept) begin
      s1_v_nxt = (in_ch.kind != KIND_NONE);
      case (in_ch.kind) inside
        KIND_ROW: begin
          cur_off_nxt  = in_ch.pc_offset;
          cur_line_nxt = in_ch.line_number;
        end
        KIND_BEGIN, KIND_END: begin
          cur_off_nxt  = 32'd0;
          cur_line_nxt = 32'd1;
        end
        default: begin
          cur_off_nxt  = cur_off_r;
          cur_line_nxt = cur_line_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_off_r  <= 32'd0;
      cur_line_r <= 32'd1;
      s1_v_r     <= 1'b0;
    end else begin
      cur_off_r  <= cur_off_nxt;
      cur_line_r <= cur_line_nxt;
      s1_v_r     <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= in_ch.kind;
      s1_pd_r   <= $signed({1'b0, in_ch.pc_offset}) - $signed({1'b0, cur_off_r});
      s1_ld_r   <= $signed({1'b0, in_ch.line_number}) - $signed({1'b0, cur_line_r});
    end
  end

  // special opcode check; a negative or large pc delta never fits
  always_comb begin
    lb_ext   = {{(DIFF_W-7){min_ldelta[7]}}, min_ldelta};
    dl       = {s1_ld_r[DIFF_W-1], s1_ld_r} - lb_ext;
    in_rng   = !dl[DIFF_W] && (dl[DIFF_W-1:0] < {{(DIFF_W-8){1'b0}}, ldelta_span});
    pd_small = (s1_pd_r[DIFF_W-1:8] == '0);
    prod     = ldelta_span * s1_pd_r[7:0];
    op_sum   = {1'b0, prod} + {9'd0, dl[7:0]} + {9'd0, SPECIAL_MIN};
  end

  always_comb begin
    push.valid       = s1_v_r;
    push.ent.kind    = s1_kind_r;
    push.ent.special = (s1_kind_r == KIND_ROW) && in_rng && pd_small &&
                       (op_sum <= {9'd0, SPECIAL_MAX});
    push.ent.op      = op_sum[7:0];
    push.ent.pd      = s1_pd_r;
    push.ent.ld      = s1_ld_r;
  end

endmodule

// File: hdl/dlpe_queue.sv
module dlpe_queue
  import dlpe_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  qlink_t push,
  output logic   push_ready,
  output qlink_t head,
  input  logic   pop
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign do_push    = push.valid && push_ready;
  assign head.valid = (cnt_r != '0);
  assign head.ent   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)     rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.ent;
  end

endmodule

// File: hdl/dlpe_back.sv
module dlpe_back
  import dlpe_pkg::*;
#(
  parameter int ADDR_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  qlink_t      head,
  output logic        pop,
  input  logic [63:0] code_start,
  dlpe_out_if.source  out_ch
);

  localparam int CNT_W = (ADDR_BYTES > 1) ? $clog2(ADDR_BYTES) : 1;

  phase_t                   ph_r, ph_nxt;
  logic signed [DIFF_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_v_r;
  logic [7:0]               byte_r;
  logic                     last_r;

  logic                     adv;
  logic [7:0]               byte_c;
  logic                     last_c;
  logic                     pop_c;
  logic signed [DIFF_W-1:0] sh_shr;
  logic [6:0]               sb;
  logic                     sdone;

  assign adv = head.valid && (!out_v_r || out_ch.ready);
  assign pop = adv && pop_c;

  // SLEB128 digit from the shift register
  assign sb     = sh_r[6:0];
  assign sh_shr = sh_r >>> 7;
  assign sdone  = (sh_shr == {DIFF_W{sb[6]}});

  // next state
  always_comb begin
    ph_nxt  = ph_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (adv) begin
      unique case (ph_r)
        PH_START: begin
          if (head.ent.kind == KIND_BEGIN) begin
            ph_nxt = PH_BEG_LEN;
          end else if (head.ent.kind == KIND_END ||
                       (head.ent.kind == KIND_ROW && !head.ent.special)) begin
            ph_nxt = PH_SLEB_PD;
            sh_nxt = head.ent.pd;
          end else begin
            ph_nxt = PH_START;
          end
        end
        PH_SLEB_PD: begin
          sh_nxt = sh_shr;
          if (sdone) ph_nxt = (head.ent.kind == KIND_END) ? PH_END_EXT : PH_ADV_LINE;
        end
        PH_ADV_LINE: begin
          sh_nxt = head.ent.ld;
          ph_nxt = PH_SLEB_LD;
        end
        PH_SLEB_LD: begin
          sh_nxt = sh_shr;
          if (sdone) ph_nxt = PH_COPY;
        end
        PH_COPY:    ph_nxt = PH_START;
        PH_BEG_LEN: ph_nxt = PH_BEG_OP;
        PH_BEG_OP: begin
          cnt_nxt = '0;
          ph_nxt  = PH_BEG_ADDR;
        end
        PH_BEG_ADDR: begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ADDR_BYTES - 1)) ph_nxt = PH_COPY;
        end
        PH_END_EXT: ph_nxt = PH_END_LEN;
        PH_END_LEN: ph_nxt = PH_END_OP;
        PH_END_OP:  ph_nxt = PH_START;
        default:    ph_nxt = PH_START;
      endcase
    end
  end

  // byte for the current phase
  always_comb begin
    byte_c = OP_COPY;
    last_c = 1'b0;
    pop_c  = 1'b0;
    unique case (ph_r) inside
      PH_START: begin
        if (head.ent.kind == KIND_BEGIN) begin
          byte_c = OP_EXTENDED;
        end else if (head.ent.kind == KIND_ROW && head.ent.special) begin
          byte_c = head.ent.op;
          last_c = 1'b1;
          pop_c  = 1'b1;
        end else begin
          byte_c = OP_ADVANCE_PC;
        end
      end
      PH_SLEB_PD, PH_SLEB_LD: byte_c = {!sdone, sb};
      PH_ADV_LINE: byte_c = OP_ADVANCE_LINE;
      PH_COPY: begin
        byte_c = OP_COPY;
        last_c = 1'b1;
        pop_c  = 1'b1;
      end
      PH_BEG_LEN:  byte_c = 8'(ADDR_BYTES + 1);
      PH_BEG_OP:   byte_c = EXT_SET_ADDRESS;
      PH_BEG_ADDR: byte_c = code_start[{cnt_r, 3'b000} +: 8];
      PH_END_EXT:  byte_c = OP_EXTENDED;
      PH_END_LEN:  byte_c = END_SEQ_LEN;
      PH_END_OP: begin
        byte_c = EXT_END_SEQUENCE;
        last_c = 1'b1;
        pop_c  = 1'b1;
      end
      default: byte_c = OP_COPY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_START;
      out_v_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (adv)               out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    if (adv) begin
      byte_r <= byte_c;
      last_r <= last_c;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.last_byte = last_r;

endmodule

// File: hdl/dwarf_line_program_encoder_top.sv
// Line-number program encoder.
// in_ch takes items (kind, pc_offset, line_number): a line row, a begin or an
// end of a sequence. out_ch gives the program one byte per transfer, with
// last_byte set on the final byte of each input item. Kind 3 gives nothing.
// Line rows that fit a special opcode give one byte; other rows give 5 to 13
// bytes, a begin gives ADDR_BYTES + 4 bytes, an end 5 to 9 bytes.
// The output sequencer emits one byte per cycle while out_ch is not stalled,
// so an item holds the output until its last byte is taken; special rows run
// at one item a cycle while out_ch is not stalled. An item passes the delta
// stage, the queue, then the output register before its first byte is valid.
// A four-deep queue lets the front keep accepting while the sequencer works
// or out_ch is stalled; a stalled byte holds in the output register.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while
// idle; this binds the user, the block itself does not enforce it.
// Synchronous reset sets the minimum line delta to 1, the line delta span
// to 7, code_start 0x401000, offset 0, line 1, and empties the queue.
module dwarf_line_program_encoder_top
  import dlpe_pkg::*;
#(
  parameter int ADDR_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  dlpe_in_if.sink     in_ch,
  dlpe_out_if.source  out_ch
);

  logic [7:0]  min_ldelta_r;
  logic [7:0]  ldelta_span_r;
  logic [63:0] code_start_r;

  qlink_t push;
  logic   push_ready;
  qlink_t head;
  logic   pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ldelta_r  <= RST_MIN_LDELTA;
      ldelta_span_r <= RST_LDELTA_SPAN;
      code_start_r  <= RST_CODE_START;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_LDELTA:  min_ldelta_r  <= cfg_wdata[7:0];
        CFG_LDELTA_SPAN: ldelta_span_r <= cfg_wdata[7:0];
        CFG_CODE_START:  code_start_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dlpe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .min_ldelta  (min_ldelta_r),
    .ldelta_span (ldelta_span_r),
    .push        (push),
    .push_ready  (push_ready)
  );

  dlpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  dlpe_back #(
    .ADDR_BYTES (ADDR_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .code_start (code_start_r),
    .out_ch     (out_ch)
  );

  // an accepted item with a known kind reaches the queue input next cycle
  a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.kind != KIND_NONE) |=> push.valid)
    else $error("accepted item not presented to queue");

  // the sequencer only retires an item that is in the queue
  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

  // retiring an item loads its final byte
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_ch.valid && out_ch.last_byte))
    else $error("item retired without last byte");

  // a push refused by a full queue stays presented until taken
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && !push_ready) |=> push.valid)
    else $error("pending queue entry dropped");

endmodule
